[sv/idl_pkg.sv]
// Package for the indexed insert/delete list: item structs, operation codes
// and the control word that steers the chain of entry cells.
// No dependencies.
`timescale 1ns / 1ps

package idl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] entry_value;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_out_item;

    // What every cell of the chain does with its word at a clock edge.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_ERASE,
        CM_ROTATE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode       mode;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

[sv/idl_cell.sv]
// One entry cell of the list chain: holds a word and takes a neighbor's word,
// the new word or the head word as the broadcast control word directs.
// Depends on idl_pkg.
`timescale 1ns / 1ps

module idl_cell #(
    parameter int IDX = 0
) (
    input  logic                               i_clk,
    input  idl_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [idl_pkg::VALUE_W-1:0] i_left_val,
    input  logic signed [idl_pkg::VALUE_W-1:0] i_right_val,
    input  logic signed [idl_pkg::VALUE_W-1:0] i_head_val,
    input  logic signed [idl_pkg::VALUE_W-1:0] i_ins_val,
    output logic signed [idl_pkg::VALUE_W-1:0] o_value
);

    localparam logic [idl_pkg::POS_W-1:0] MY_IDX = idl_pkg::POS_W'(IDX);

    logic signed [idl_pkg::VALUE_W-1:0] r_value;
    logic signed [idl_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.mode)
            idl_pkg::CM_INSERT: begin
                // Entries at and above the position move up one place.
                if (MY_IDX > i_ctl.pos) begin
                    n_value = i_left_val;
                end else if (MY_IDX == i_ctl.pos) begin
                    n_value = i_ins_val;
                end
            end
            idl_pkg::CM_ERASE: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_value = i_right_val;
                end
            end
            idl_pkg::CM_ROTATE: begin
                // Rotate the used part of the list down by one; pos is the
                // last used place, which receives the old head.
                if (MY_IDX < i_ctl.pos) begin
                    n_value = i_right_val;
                end else if (MY_IDX == i_ctl.pos) begin
                    n_value = i_head_val;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[sv/indexed_insert_delete_list.sv]
// Top level of the indexed insert/delete list: control sequencer, output
// register and the chain of entry cells. Depends on idl_pkg and idl_cell.
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Payload
// --------  ---------  -----------------------------------  -----------------------
// input     in         i_in_valid, o_in_ready, i_in_item    func, position, value
// output    out        o_out_valid, i_out_ready, o_out_item ok, entry, count, last
//
// Insert, erase and the unused selector apply to the whole cell chain in the
// cycle the item is accepted and give one result in the output register the
// cycle after; these items can follow each other every cycle unless the output stalls.
// A dump of N entries gives N results, one per cycle while the output is not
// stalled, by rotating the used cells of the chain past the head; after N steps
// the list is back in order. Its first result is loaded in the cycle after the
// dump is accepted, and the input stays blocked until the last one is loaded.
// Synchronous active-low reset clears the length and the control state only.
// A stalled output holds the register and, during a dump, stops the rotation.

module indexed_insert_delete_list #(
    parameter int CAPACITY = idl_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  idl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output idl_pkg::t_out_item o_out_item
);

    // The length counter must be able to hold CAPACITY itself.
    localparam int UW = $clog2(CAPACITY + 1);
    // Width wide enough to compare a position with the length.
    localparam int CW = (UW > idl_pkg::POS_W) ? UW : idl_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state             r_state,     n_state;
    logic [UW-1:0]      r_used,      n_used;
    logic [UW-1:0]      r_left,      n_left;
    logic               r_out_valid, n_out_valid;
    idl_pkg::t_out_item r_out,       n_out;

    idl_pkg::t_cell_ctl w_ctl;
    logic signed [idl_pkg::VALUE_W-1:0] w_val [0:CAPACITY-1];

    logic w_slot_free;
    logic w_accept;
    logic [CW-1:0] w_pos_ext;
    logic [CW-1:0] w_used_ext;
    logic w_ins_ok;
    logic w_era_ok;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_pos_ext  = CW'(i_in_item.position);
    assign w_used_ext = CW'(r_used);
    assign w_ins_ok   = (w_pos_ext <= w_used_ext) && (r_used < UW'(CAPACITY));
    assign w_era_ok   = w_pos_ext < w_used_ext;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctl.mode  = idl_pkg::CM_HOLD;
        w_ctl.pos   = i_in_item.position;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid       = 1'b1;
                    n_out.ok          = 1'b0;
                    n_out.entry_value = '0;
                    n_out.count       = idl_pkg::COUNT_W'(r_used);
                    n_out.last        = 1'b1;
                    case (i_in_item.func)
                        idl_pkg::FN_INSERT: begin
                            if (w_ins_ok) begin
                                w_ctl.mode  = idl_pkg::CM_INSERT;
                                n_used      = r_used + UW'(1);
                                n_out.ok    = 1'b1;
                                n_out.count = idl_pkg::COUNT_W'(r_used + UW'(1));
                            end
                        end
                        idl_pkg::FN_ERASE: begin
                            if (w_era_ok) begin
                                w_ctl.mode  = idl_pkg::CM_ERASE;
                                n_used      = r_used - UW'(1);
                                n_out.ok    = 1'b1;
                                n_out.count = idl_pkg::COUNT_W'(r_used - UW'(1));
                            end
                        end
                        idl_pkg::FN_DUMP: begin
                            // An empty list answers with one failed result;
                            // otherwise the dump runs in its own state.
                            if (r_used != '0) begin
                                n_out_valid = 1'b0;
                                n_left      = r_used;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_out.ok = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_slot_free) begin
                    w_ctl.mode        = idl_pkg::CM_ROTATE;
                    w_ctl.pos         = idl_pkg::POS_W'(r_used - UW'(1));
                    n_out_valid       = 1'b1;
                    n_out.ok          = 1'b1;
                    n_out.entry_value = w_val[0];
                    n_out.count       = idl_pkg::COUNT_W'(r_used);
                    n_out.last        = (r_left == UW'(1));
                    n_left            = r_left - UW'(1);
                    if (r_left == UW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // The chain of entry cells, cell 0 at the head of the list.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [idl_pkg::VALUE_W-1:0] w_left;
        logic signed [idl_pkg::VALUE_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_val[g+1];
        end

        idl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_head_val  (w_val[0]),
            .i_ins_val   (i_in_item.item_value),
            .o_value     (w_val[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[dv/tb_indexed_insert_delete_list.sv]
// Self-checking testbench for the indexed insert/delete list: it drives insert, erase and
// dump items and compares every result against a local list model.
// Depends on idl_pkg and the indexed_insert_delete_list RTL.
`timescale 1ns / 1ps

module tb_indexed_insert_delete_list;

    localparam int LIST_CAP = idl_pkg::CAPACITY_DEF;

    // The selector value that the package leaves unassigned; the block must reject it.
    localparam logic [idl_pkg::FUNC_W-1:0] FN_SPARE = 2'd3;

    // The run ends with a failure after this many cycles in which neither channel moves
    // an item. A correct run never comes close, even under the heaviest random stalls.
    localparam int STALL_LIMIT = 500;

    // Percentage of cycles in which each side idles while random idling is enabled.
    localparam int IDLE_PCT = 23;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    idl_pkg::t_in_item  in_item = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    idl_pkg::t_out_item o_out_item;

    indexed_insert_delete_list #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Items waiting to be driven, and results that the list model says must come back.
    idl_pkg::t_in_item  stim_items[$];
    idl_pkg::t_out_item expected_results[$];

    // Local copy of the list. Only words below list_len are ever read, so the words
    // above it never need a defined value.
    logic signed [idl_pkg::VALUE_W-1:0] list_words[LIST_CAP];
    int unsigned                        list_len = 0;

    int  items_queued = 0;
    int  items_accepted = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    // While set, neither side idles; the stimulus uses this for one long dense stretch.
    bit  no_idle = 1'b0;

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic idl_pkg::t_out_item make_result(input logic ok,
                                                       input logic [idl_pkg::VALUE_W-1:0] word,
                                                       input logic last);
        idl_pkg::t_out_item r;
        r.ok          = ok;
        r.entry_value = word;
        r.count       = list_len[idl_pkg::COUNT_W-1:0];
        r.last        = last;
        return r;
    endfunction

    // Applies one accepted item to the local list and queues the results it must cause.
    // Insert moves the words at and above the position up, erase those above it down,
    // one place; a rejected insert or erase leaves the list as it is but still gives one result.
    task automatic apply_list_op(input idl_pkg::t_in_item it);
        int unsigned pos;
        logic        ok;
        pos = it.position;
        ok  = 1'b0;
        case (it.func)
            idl_pkg::FN_INSERT: begin
                if (pos <= list_len && list_len < LIST_CAP) begin
                    for (int unsigned i = list_len; i > pos; i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[pos] = it.item_value;
                    list_len++;
                    ok = 1'b1;
                end
                expected_results.push_back(make_result(ok, '0, 1'b1));
            end
            idl_pkg::FN_ERASE: begin
                if (pos < list_len) begin
                    for (int unsigned i = pos; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len--;
                    ok = 1'b1;
                end
                expected_results.push_back(make_result(ok, '0, 1'b1));
            end
            idl_pkg::FN_DUMP: begin
                // An empty list still answers, with a single rejected result.
                if (list_len == 0) begin
                    expected_results.push_back(make_result(1'b0, '0, 1'b1));
                end else begin
                    for (int unsigned i = 0; i < list_len; i++) begin
                        expected_results.push_back(
                            make_result(1'b1, list_words[i], i + 1 == list_len));
                    end
                end
            end
            default: begin
                expected_results.push_back(make_result(1'b0, '0, 1'b1));
            end
        endcase
    endtask

    // Sender. An item is taken over at an edge where valid and ready are both high; the
    // next one is offered in the same step, or valid drops, so valid gets at most one
    // assignment per edge and never falls while an item is still waiting.
    always @(posedge i_clk) begin : drive_items
        logic took;
        took = in_valid && o_in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (took) begin
                apply_list_op(in_item);
                items_accepted++;
            end
            if (!in_valid || took) begin
                if (stim_items.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_item  <= stim_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every result taken is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        idl_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected: %h", o_out_item));
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.ok !== want.ok)
                    note_mismatch($sformatf("ok is %b, expected %b",
                                            o_out_item.ok, want.ok));
                if (o_out_item.entry_value !== want.entry_value)
                    note_mismatch($sformatf("entry_value is %h, expected %h",
                                            o_out_item.entry_value, want.entry_value));
                if (o_out_item.count !== want.count)
                    note_mismatch($sformatf("count is %0d, expected %0d",
                                            o_out_item.count, want.count));
                if (o_out_item.last !== want.last)
                    note_mismatch($sformatf("last is %b, expected %b",
                                            o_out_item.last, want.last));
            end
        end
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus side. gen_len tracks the list length that the queued items will leave
    // behind, so that sequences can aim at valid positions, a full store or an empty one.
    int unsigned gen_len = 0;

    task automatic queue_op(input logic [idl_pkg::FUNC_W-1:0] fn, input int unsigned pos,
                            input logic [idl_pkg::VALUE_W-1:0] word);
        idl_pkg::t_in_item it;
        it.func       = fn;
        it.position   = pos[idl_pkg::POS_W-1:0];
        it.item_value = word;
        stim_items.push_back(it);
        items_queued++;
        if (fn == idl_pkg::FN_INSERT && pos <= gen_len && gen_len < LIST_CAP)
            gen_len++;
        else if (fn == idl_pkg::FN_ERASE && pos < gen_len)
            gen_len--;
    endtask

    // Mostly random words, with the extremes of the signed range mixed in.
    function automatic logic [idl_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Holds the stimulus back until every queued item is in and every result is out.
    task automatic wait_until_drained();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // One random sequence. Most are well-formed operations on valid positions, so the
    // list really grows, shrinks, fills up and empties; the rest is unconstrained noise.
    task automatic add_random_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // Random walk: inserts are favored while the list is short.
            if (gen_len < LIST_CAP &&
                (gen_len == 0 || $urandom_range(0, LIST_CAP) >= gen_len))
                queue_op(idl_pkg::FN_INSERT, $urandom_range(0, gen_len), pick_word());
            else
                queue_op(idl_pkg::FN_ERASE, $urandom_range(0, gen_len - 1), pick_word());
        end else if (pick < 52) begin
            // Fill the store, try one insert too many, then read everything out.
            while (gen_len < LIST_CAP)
                queue_op(idl_pkg::FN_INSERT, $urandom_range(0, gen_len), pick_word());
            queue_op(idl_pkg::FN_INSERT, $urandom_range(0, 63), pick_word());
            queue_op(idl_pkg::FN_DUMP, $urandom_range(0, 63), pick_word());
        end else if (pick < 57) begin
            // Empty the list, erase once more on the empty list, then dump it.
            while (gen_len > 0)
                queue_op(idl_pkg::FN_ERASE, $urandom_range(0, gen_len - 1), pick_word());
            queue_op(idl_pkg::FN_ERASE, $urandom_range(0, 63), pick_word());
            queue_op(idl_pkg::FN_DUMP, $urandom_range(0, 63), pick_word());
        end else if (pick < 72) begin
            queue_op(idl_pkg::FN_DUMP, $urandom_range(0, 63), pick_word());
        end else if (pick < 80) begin
            // Positions just past the end: the boundary between accepted and rejected.
            if ($urandom_range(0, 1) == 0)
                queue_op(idl_pkg::FN_INSERT, gen_len + $urandom_range(0, 1), pick_word());
            else
                queue_op(idl_pkg::FN_ERASE, gen_len, pick_word());
        end else begin
            queue_op(idl_pkg::FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                     pick_word());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every selector, the empty list, out-of-range positions on both
        // sides of the end, inserts at head, tail and middle, and the signed extremes.
        queue_op(idl_pkg::FN_DUMP,   0,  32'h0);           // dump of an empty list
        queue_op(idl_pkg::FN_ERASE,  0,  32'h1234_5678);   // erase on an empty list
        queue_op(idl_pkg::FN_INSERT, 1,  32'h1);           // insert past the end
        queue_op(idl_pkg::FN_INSERT, 0,  32'h7FFF_FFFF);
        queue_op(idl_pkg::FN_INSERT, 0,  32'h8000_0000);   // insert at the head
        queue_op(idl_pkg::FN_INSERT, 2,  32'hFFFF_FFFF);   // insert at the tail
        queue_op(idl_pkg::FN_INSERT, 1,  32'h0);           // insert in the middle
        queue_op(FN_SPARE,           63, 32'h5555_5555);   // unused selector
        queue_op(idl_pkg::FN_DUMP,   63, 32'hAAAA_AAAA);
        queue_op(idl_pkg::FN_ERASE,  63, 32'h0);           // erase far out of range
        queue_op(idl_pkg::FN_ERASE,  4,  32'h0);           // erase just past the end
        queue_op(idl_pkg::FN_ERASE,  1,  32'h0);           // erase in the middle
        queue_op(idl_pkg::FN_ERASE,  2,  32'h0);           // erase the last entry
        queue_op(idl_pkg::FN_INSERT, 42, 32'h0);           // far past the end
        queue_op(idl_pkg::FN_DUMP,   21, 32'h0);

        // The stimulus pauses here until every result of the directed part is back.
        wait_until_drained();

        while (items_queued < 210)
            add_random_sequence();
        wait_until_drained();

        // A long dense stretch in which neither side idles.
        no_idle = 1'b1;
        while (items_queued < 320)
            add_random_sequence();
        wait_until_drained();
        no_idle = 1'b0;

        while (items_queued < 470)
            add_random_sequence();
        wait_until_drained();

        // A quiet stretch at the end, in which any stray result would still be caught.
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/idl_pkg.sv
sv/idl_cell.sv
sv/indexed_insert_delete_list.sv
dv/tb_indexed_insert_delete_list.sv
